@@ rtl/tstc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the touch swipe and tap classifier.
// Used by every module under rtl; it depends on nothing else.
package tstc_pkg;

	// Threshold registers are twelve bits wide, the time limit thirty-two.
	localparam int LIMIT_W = 12;
	localparam int TIME_W  = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_DOWN = 2'd1,
		EV_MOVE = 2'd2,
		EV_UP   = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		G_NONE  = 3'd0,
		G_TAP   = 3'd1,
		G_UP    = 3'd2,
		G_RIGHT = 3'd3,
		G_DOWN  = 3'd4,
		G_LEFT  = 3'd5
	} gesture_t;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLIDE_DIST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLIDE_TIME = 2'd2;

	localparam logic [LIMIT_W-1:0] TAP_MAX_RESET    = 12'd150;
	localparam logic [LIMIT_W-1:0] SLIDE_DIST_RESET = 12'd50;
	localparam logic [TIME_W-1:0]  SLIDE_TIME_RESET = 32'd100000;

	typedef struct packed {
		logic [LIMIT_W-1:0] tap_max_distance;
		logic [LIMIT_W-1:0] slide_min_distance;
		logic [TIME_W-1:0]  slide_min_time_us;
	} cfg_t;

endpackage

@@ rtl/touch_swipe_tap_classifier.sv @@
`timescale 1ns / 1ps
// Touch swipe and tap classifier, top level.
// Each accepted sample passes through the input register and then the result
// register, which raises out_valid. Throughput: one sample per cycle while
// out_ready is high, limited by the single input and result registers.
// Reset (arst_n low, asynchronous): both stages empty, motion sums and previous
// sample cleared, thresholds back to 150, 50 and 100000 us.
module touch_swipe_tap_classifier #(
	parameter int COORD_BITS = 12,
	parameter int DIST_BITS  = 18
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         event_req,
	input  logic [COORD_BITS-1:0]              pos_x,
	input  logic [COORD_BITS-1:0]              pos_y,
	input  logic [tstc_pkg::TIME_W-1:0]        now_us,

	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         gesture,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tstc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tstc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// The block is a two-register pipeline. An accepted item is captured in
	// the input register (stage 1). From there the stage's logic updates
	// the motion tracker and, for an up event, classifies the motion that
	// was accumulated before this item. The decision lands in the result
	// register, which holds it until the consumer takes it.

	tstc_pkg::cfg_t                    cfg;
	logic                              valid_s1;
	tstc_pkg::event_t                  event_s1;
	logic [COORD_BITS-1:0]             pos_x_s1, pos_y_s1;
	logic [tstc_pkg::TIME_W-1:0]       now_us_s1;

	logic                              out_valid_q;
	tstc_pkg::gesture_t                gesture_q;

	logic                              in_fire, advance;
	logic signed [DIST_BITS-1:0]       sum_dx, sum_dy;
	logic [tstc_pkg::TIME_W-1:0]       elapsed_us;
	tstc_pkg::gesture_t                gesture_d;

	// Stage 1 moves on when the result register is empty or being emptied.
	// Stage 1 takes a new item whenever it is empty or moving on, so a new
	// sample can enter while an earlier result still waits at the output.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	tstc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Control state of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input register needs no reset.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			event_s1  <= tstc_pkg::event_t'(event_req);
			pos_x_s1  <= pos_x;
			pos_y_s1  <= pos_y;
			now_us_s1 <= now_us;
		end
	end

	// The tracker presents the sums as they stand before this item; its
	// registers take the updated values at the same edge that loads the result.
	tstc_track #(
		.COORD_BITS (COORD_BITS),
		.DIST_BITS  (DIST_BITS)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.event_kind (event_s1),
		.pos_x      (pos_x_s1),
		.pos_y      (pos_y_s1),
		.now_us     (now_us_s1),
		.sum_dx     (sum_dx),
		.sum_dy     (sum_dy),
		.elapsed_us (elapsed_us)
	);

	// Every event other than up reports no gesture.
	tstc_classify #(
		.DIST_BITS (DIST_BITS)
	) u_classify (
		.is_up      (event_s1 == tstc_pkg::EV_UP),
		.sum_dx     (sum_dx),
		.sum_dy     (sum_dy),
		.elapsed_us (elapsed_us),
		.cfg        (cfg),
		.gesture    (gesture_d)
	);

	// Result register: filled by stage 1, emptied by the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gesture_q <= gesture_d;
		end
	end

	assign out_valid = out_valid_q;
	assign gesture   = gesture_q;

	// Only an up event can produce a gesture code other than none.
	a_gesture_only_on_up: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (event_s1 != tstc_pkg::EV_UP) |=> gesture_q == tstc_pkg::G_NONE)
		else $error("gesture reported for an item that is not an up event");

	// The elapsed time only changes on a down or a move item.
	a_elapsed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (event_s1 != tstc_pkg::EV_MOVE) && (event_s1 != tstc_pkg::EV_DOWN)
		|=> $stable(elapsed_us))
		else $error("elapsed time changed on a none or up item");

	// An item leaving stage 1 always lands in the result register.
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register empty after stage 1 moved on");

	// A result shown at the output is always a defined gesture code.
	a_gesture_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> gesture_q <= tstc_pkg::G_LEFT)
		else $error("gesture code out of range");

endmodule

@@ rtl/tstc_cfg.sv @@
`timescale 1ns / 1ps
// Configuration register file of the classifier: three threshold registers.
// Depends on tstc_pkg for the register indexes, reset values and cfg_t.
module tstc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tstc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tstc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output tstc_pkg::cfg_t                     cfg
);

	tstc_pkg::cfg_t cfg_q;

	// Each write lands directly in its register, so the port is always ready.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_max_distance   <= tstc_pkg::TAP_MAX_RESET;
			cfg_q.slide_min_distance <= tstc_pkg::SLIDE_DIST_RESET;
			cfg_q.slide_min_time_us  <= tstc_pkg::SLIDE_TIME_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tstc_pkg::CFG_TAP_MAX: begin
					cfg_q.tap_max_distance <= cfg_data[tstc_pkg::LIMIT_W-1:0];
				end
				tstc_pkg::CFG_SLIDE_DIST: begin
					cfg_q.slide_min_distance <= cfg_data[tstc_pkg::LIMIT_W-1:0];
				end
				tstc_pkg::CFG_SLIDE_TIME: begin
					cfg_q.slide_min_time_us <= cfg_data[tstc_pkg::TIME_W-1:0];
				end
				default: begin
					// Indexes past the register list are ignored.
				end
			endcase
		end
	end

endmodule

@@ rtl/tstc_track.sv @@
`timescale 1ns / 1ps
// Motion tracker: previous sample and the saturating distance and time sums.
// Depends on tstc_pkg for the event codes and the time width.
module tstc_track #(
	parameter int COORD_BITS = 12,
	parameter int DIST_BITS  = 18
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  tstc_pkg::event_t                  event_kind,
	input  logic [COORD_BITS-1:0]             pos_x,
	input  logic [COORD_BITS-1:0]             pos_y,
	input  logic [tstc_pkg::TIME_W-1:0]       now_us,
	output logic signed [DIST_BITS-1:0]       sum_dx,
	output logic signed [DIST_BITS-1:0]       sum_dy,
	output logic [tstc_pkg::TIME_W-1:0]       elapsed_us
);

	localparam int DW = COORD_BITS + 1;
	localparam int SW = ((DIST_BITS > DW) ? DIST_BITS : DW) + 1;
	localparam logic signed [SW-1:0] DHI = {{(SW-DIST_BITS+1){1'b0}}, {(DIST_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] DLO = {{(SW-DIST_BITS+1){1'b1}}, {(DIST_BITS-1){1'b0}}};

	logic [COORD_BITS-1:0]            prev_x_q, prev_y_q;
	logic [tstc_pkg::TIME_W-1:0]      prev_time_q, elapsed_q;
	logic signed [DIST_BITS-1:0]      sum_dx_q, sum_dy_q;

	logic signed [DW-1:0]             dx, dy;
	logic signed [SW-1:0]             rx, ry;
	logic signed [DIST_BITS-1:0]      sx, sy;
	logic [tstc_pkg::TIME_W-1:0]      dt;
	logic [tstc_pkg::TIME_W:0]        t_sum;
	logic [tstc_pkg::TIME_W-1:0]      t_sat;

	function automatic logic signed [DIST_BITS-1:0] clamp(input logic signed [SW-1:0] v);
		logic signed [DIST_BITS-1:0] r;
		if (v > DHI) begin
			r = DHI[DIST_BITS-1:0];
		end else if (v < DLO) begin
			r = DLO[DIST_BITS-1:0];
		end else begin
			r = v[DIST_BITS-1:0];
		end
		return r;
	endfunction

	always_comb begin
		dx = $signed({1'b0, pos_x}) - $signed({1'b0, prev_x_q});
		dy = $signed({1'b0, pos_y}) - $signed({1'b0, prev_y_q});
		rx = $signed({{(SW-DIST_BITS){sum_dx_q[DIST_BITS-1]}}, sum_dx_q})
			+ $signed({{(SW-DW){dx[DW-1]}}, dx});
		ry = $signed({{(SW-DIST_BITS){sum_dy_q[DIST_BITS-1]}}, sum_dy_q})
			+ $signed({{(SW-DW){dy[DW-1]}}, dy});
		sx = clamp(rx);
		sy = clamp(ry);
		// The timestamp difference wraps; the running total saturates.
		dt    = now_us - prev_time_q;
		t_sum = {1'b0, elapsed_q} + {1'b0, dt};
		t_sat = t_sum[tstc_pkg::TIME_W] ? '1 : t_sum[tstc_pkg::TIME_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_time_q <= '0;
			sum_dx_q    <= '0;
			sum_dy_q    <= '0;
			elapsed_q   <= '0;
		end else if (step) begin
			prev_x_q    <= pos_x;
			prev_y_q    <= pos_y;
			prev_time_q <= now_us;
			unique case (event_kind)
				tstc_pkg::EV_DOWN: begin
					sum_dx_q  <= '0;
					sum_dy_q  <= '0;
					elapsed_q <= '0;
				end
				tstc_pkg::EV_MOVE: begin
					sum_dx_q  <= sx;
					sum_dy_q  <= sy;
					elapsed_q <= t_sat;
				end
				default: begin
					// No event and up leave the sums as they are.
				end
			endcase
		end
	end

	assign sum_dx     = sum_dx_q;
	assign sum_dy     = sum_dy_q;
	assign elapsed_us = elapsed_q;

endmodule

@@ rtl/tstc_classify.sv @@
`timescale 1ns / 1ps
// Gesture decision from the accumulated motion and the threshold registers.
// Depends on tstc_pkg for cfg_t, the gesture codes and the limit widths.
module tstc_classify #(
	parameter int DIST_BITS = 18
) (
	input  logic                              is_up,
	input  logic signed [DIST_BITS-1:0]       sum_dx,
	input  logic signed [DIST_BITS-1:0]       sum_dy,
	input  logic [tstc_pkg::TIME_W-1:0]       elapsed_us,
	input  tstc_pkg::cfg_t                    cfg,
	output tstc_pkg::gesture_t                gesture
);

	localparam int CW = (DIST_BITS > tstc_pkg::LIMIT_W) ? DIST_BITS : tstc_pkg::LIMIT_W;

	logic                    neg_x, neg_y;
	logic [DIST_BITS-1:0]    mag_x, mag_y;
	logic [CW-1:0]           ax, ay, tap, sd;
	logic                    x_dom, y_dom, is_tap, slow;

	always_comb begin
		neg_x = sum_dx[DIST_BITS-1];
		neg_y = sum_dy[DIST_BITS-1];
		// The magnitude of the most negative sum still fits as unsigned.
		// It is formed at the sum's own width before any widening.
		mag_x = neg_x ? (~sum_dx + 1'b1) : sum_dx;
		mag_y = neg_y ? (~sum_dy + 1'b1) : sum_dy;
		ax  = CW'(mag_x);
		ay  = CW'(mag_y);
		tap = CW'(cfg.tap_max_distance);
		sd  = CW'(cfg.slide_min_distance);
		x_dom  = ax > ay;
		y_dom  = ay > ax;
		is_tap = (ax < tap) && (ay < tap);
		slow   = elapsed_us > cfg.slide_min_time_us;

		// A signed sum lies beyond the slide distance in its own direction
		// exactly when its sign matches and its magnitude exceeds the limit.
		gesture = tstc_pkg::G_NONE;
		if (is_up) begin
			priority if (is_tap) begin
				gesture = tstc_pkg::G_TAP;
			end else if (slow && neg_y && (ay > sd) && y_dom) begin
				gesture = tstc_pkg::G_UP;
			end else if (slow && !neg_x && (ax > sd) && x_dom) begin
				gesture = tstc_pkg::G_RIGHT;
			end else if (slow && !neg_y && (ay > sd) && y_dom) begin
				gesture = tstc_pkg::G_DOWN;
			end else if (slow && neg_x && (ax > sd) && x_dom) begin
				gesture = tstc_pkg::G_LEFT;
			end else begin
				gesture = tstc_pkg::G_NONE;
			end
		end
	end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the touch swipe and tap classifier.
// Depends on tstc_pkg and touch_swipe_tap_classifier from the rtl folder.
module testbench;
	import tstc_pkg::*;

	localparam int COORD_W = 12;
	localparam int DIST_W = 18;
	// Signed limits of the distance accumulators.
	localparam int DIST_HI = (1 << (DIST_W - 1)) - 1;
	localparam int DIST_LO = -DIST_HI - 1;
	localparam logic [COORD_W-1:0] COORD_MAX = '1;
	localparam logic [COORD_W-1:0] COORD_MID = COORD_W'(2048);
	// Cycles without any handshake on any port before the run is declared hung.
	localparam int STALL_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 245;
	localparam int NUM_PHASES = 7;
	// The result register sits behind the input register; the drain adds spare waiting.
	localparam int DRAIN_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] event_req = EV_NONE;
	logic [COORD_W-1:0] pos_x = '0;
	logic [COORD_W-1:0] pos_y = '0;
	logic [TIME_W-1:0] now_us = '0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] gesture;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_TAP_MAX;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Our own copy of the classifier state: the previous sample, the motion
	// sums and the thresholds, all at the widths the block uses.
	logic [COORD_W-1:0] last_x = '0;
	logic [COORD_W-1:0] last_y = '0;
	logic [TIME_W-1:0] last_t = '0;
	logic signed [DIST_W-1:0] travel_x = '0;
	logic signed [DIST_W-1:0] travel_y = '0;
	logic [TIME_W-1:0] move_time = '0;
	logic [LIMIT_W-1:0] tap_limit = TAP_MAX_RESET;
	logic [LIMIT_W-1:0] slide_dist = SLIDE_DIST_RESET;
	logic [TIME_W-1:0] slide_time = SLIDE_TIME_RESET;

	// Gestures still owed by the block, oldest first.
	gesture_t gesture_q[$];
	int errors = 0;
	int items = 0;
	int quiet_cycles = 0;
	int hold_cycles = 0;
	// When set, neither side inserts idle cycles.
	bit no_idle = 1'b0;

	// A row of the directed table. Rows with fixed set carry an expected
	// gesture that is plain from the row itself; the rest use the predictor.
	typedef struct {
		event_t ev;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [TIME_W-1:0] t;
		bit fixed;
		gesture_t want;
	} sample_row_t;

	// The directed part runs with the reset thresholds: tap 150, slide 50,
	// slide time 100000 us.
	sample_row_t dir_rows [24] = '{
		// Up straight after reset: all sums are zero, so it is a tap.
		'{EV_UP,   12'd0,    12'd0,    32'd0,          1'b1, G_TAP},
		// An idle sample at the top corner and the last timestamp.
		'{EV_NONE, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b1, G_NONE},
		// Full-width slide to the right.
		'{EV_DOWN, 12'd0,    12'd0,    32'd0,          1'b1, G_NONE},
		'{EV_MOVE, 12'd4095, 12'd0,    32'd200000,     1'b1, G_NONE},
		'{EV_UP,   12'd4095, 12'd0,    32'd200001,     1'b0, G_NONE},
		// Full-height slide up.
		'{EV_DOWN, 12'd4095, 12'd4095, 32'd0,          1'b1, G_NONE},
		'{EV_MOVE, 12'd4095, 12'd0,    32'd150000,     1'b1, G_NONE},
		'{EV_UP,   12'd4095, 12'd0,    32'd150000,     1'b0, G_NONE},
		// Full-height slide down.
		'{EV_DOWN, 12'd0,    12'd0,    32'd0,          1'b1, G_NONE},
		'{EV_MOVE, 12'd0,    12'd4095, 32'd150000,     1'b1, G_NONE},
		'{EV_UP,   12'd0,    12'd4095, 32'd150000,     1'b0, G_NONE},
		// Full-width slide to the left.
		'{EV_DOWN, 12'd4095, 12'd0,    32'd0,          1'b1, G_NONE},
		'{EV_MOVE, 12'd0,    12'd0,    32'd150000,     1'b1, G_NONE},
		'{EV_UP,   12'd0,    12'd0,    32'd150000,     1'b0, G_NONE},
		// The timestamp wraps between down and move; the move time is the
		// modular difference.
		'{EV_DOWN, 12'd0,    12'd0,    32'hFFFF_0000, 1'b1, G_NONE},
		'{EV_MOVE, 12'd1000, 12'd0,    32'h0002_0000, 1'b1, G_NONE},
		'{EV_UP,   12'd1000, 12'd0,    32'h0002_0001, 1'b0, G_NONE},
		// Two moves of maximum duration saturate the move time; equal
		// distances on both axes leave no dominant axis.
		'{EV_DOWN, 12'd0,    12'd0,    32'd0,          1'b1, G_NONE},
		'{EV_MOVE, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b1, G_NONE},
		'{EV_MOVE, 12'd4095, 12'd4095, 32'hFFFF_FFFE, 1'b1, G_NONE},
		'{EV_UP,   12'd4095, 12'd4095, 32'hFFFF_FFFE, 1'b0, G_NONE},
		// Too far for a tap, too quick for a slide.
		'{EV_DOWN, 12'd100,  12'd100,  32'd0,          1'b1, G_NONE},
		'{EV_MOVE, 12'd300,  12'd100,  32'd50000,      1'b1, G_NONE},
		'{EV_UP,   12'd300,  12'd100,  32'd50000,      1'b0, G_NONE}
	};

	touch_swipe_tap_classifier #(
		.COORD_BITS(COORD_W),
		.DIST_BITS (DIST_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.event_req(event_req),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.now_us   (now_us),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gesture  (gesture),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Adds one coordinate step to a distance sum, holding it at the signed
	// limits of the accumulator.
	function automatic int sat_travel(int acc, int step);
		int s;
		s = acc + step;
		if (s > DIST_HI)
			return DIST_HI;
		if (s < DIST_LO)
			return DIST_LO;
		return s;
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(int v);
		if (v < 0)
			return '0;
		if (v > int'(COORD_MAX))
			return COORD_MAX;
		return COORD_W'(v);
	endfunction

	// Classification on an up event. The tap test comes first; the four slides
	// are only looked at once the move time is long enough, in the order up,
	// right, down, left.
	function automatic gesture_t classify_motion();
		int sx, sy, ax, ay, sd;
		sx = int'(travel_x);
		sy = int'(travel_y);
		ax = (sx < 0) ? -sx : sx;
		ay = (sy < 0) ? -sy : sy;
		sd = int'(slide_dist);
		if (ax < int'(tap_limit) && ay < int'(tap_limit))
			return G_TAP;
		if (move_time > slide_time) begin
			if (sy < -sd && ay > ax)
				return G_UP;
			if (sx > sd && ax > ay)
				return G_RIGHT;
			if (sy > sd && ay > ax)
				return G_DOWN;
			if (sx < -sd && ax > ay)
				return G_LEFT;
		end
		return G_NONE;
	endfunction

	// Applies one accepted sample to the predicted state and returns the
	// gesture that the block should report for it.
	function automatic gesture_t track_sample(event_t ev, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [TIME_W-1:0] t);
		gesture_t g;
		logic [TIME_W-1:0] dt;
		logic [TIME_W:0] tsum;
		g = G_NONE;
		case (ev)
			EV_DOWN: begin
				travel_x = '0;
				travel_y = '0;
				move_time = '0;
			end
			EV_MOVE: begin
				// The time step is taken modulo 2^32, the sum saturates.
				dt = t - last_t;
				tsum = {1'b0, move_time} + {1'b0, dt};
				travel_x = DIST_W'(sat_travel(int'(travel_x), int'(x) - int'(last_x)));
				travel_y = DIST_W'(sat_travel(int'(travel_y), int'(y) - int'(last_y)));
				move_time = tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
			end
			EV_UP: g = classify_motion();
			default: ;
		endcase
		// Whatever its kind, the sample becomes the previous one.
		last_x = x;
		last_y = y;
		last_t = t;
		return g;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = int'($urandom_range(0, 99));
		if (r < 55)
			return 0;
		if (r < 90)
			return int'($urandom_range(1, 3));
		if (r < 98)
			return int'($urandom_range(4, 12));
		return int'($urandom_range(20, 60));
	endfunction

	// Offers one sample after a random idle stretch and holds it until the
	// block takes it. Valid is left high on return, so the next call either
	// replaces the payload or lowers valid at the next falling edge.
	task automatic send_sample(event_t ev, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [TIME_W-1:0] t, bit fixed, gesture_t want);
		int gap;
		gesture_t g;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		event_req <= ev;
		pos_x <= x;
		pos_y <= y;
		now_us <= t;
		do @(posedge clk); while (!in_ready);
		g = track_sample(ev, x, y, t);
		gesture_q.push_back(fixed ? want : g);
		items++;
	endtask

	// Stops sending and waits until every owed gesture has come back, then adds
	// a spare wait before returning.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (gesture_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; cfg_valid stays high for a following write and is
	// lowered by the caller.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TAP_MAX:    tap_limit = data[LIMIT_W-1:0];
			CFG_SLIDE_DIST: slide_dist = data[LIMIT_W-1:0];
			CFG_SLIDE_TIME: slide_time = data;
			default: ;
		endcase
	endtask

	// Loads all three thresholds while the block is idle. The unused upper
	// bits of the twelve-bit registers carry random junk.
	task automatic set_thresholds(logic [LIMIT_W-1:0] tap, logic [LIMIT_W-1:0] slide_lim,
			logic [TIME_W-1:0] tm);
		logic [CFG_DATA_W-1:0] junk;
		drain();
		junk = $urandom();
		write_reg(CFG_TAP_MAX, {junk[CFG_DATA_W-1:LIMIT_W], tap});
		junk = $urandom();
		write_reg(CFG_SLIDE_DIST, {junk[CFG_DATA_W-1:LIMIT_W], slide_lim});
		write_reg(CFG_SLIDE_TIME, tm);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A well-formed gesture: down, a few moves biased along one axis, up.
	// The step scale picks between tap-sized and slide-sized motion.
	task automatic run_swipe();
		int x, y, m, axis, sgn, along, across;
		logic [TIME_W-1:0] t;
		x = int'($urandom_range(0, 4095));
		y = int'($urandom_range(0, 4095));
		t = $urandom();
		send_sample(EV_DOWN, clamp_coord(x), clamp_coord(y), t, 1'b0, G_NONE);
		case ($urandom_range(0, 2))
			0: m = 20;
			1: m = 300;
			default: m = 2000;
		endcase
		axis = int'($urandom_range(0, 1));
		sgn = ($urandom_range(0, 1) == 0) ? -1 : 1;
		repeat ($urandom_range(1, 6)) begin
			// An idle sample now and then only refreshes the previous sample.
			if ($urandom_range(0, 9) == 0)
				send_sample(EV_NONE, clamp_coord(x), clamp_coord(y), t, 1'b0, G_NONE);
			along = sgn * int'($urandom_range(0, m));
			across = int'($urandom_range(0, m / 4)) - m / 8;
			if (axis == 0) begin
				x = int'(clamp_coord(x + along));
				y = int'(clamp_coord(y + across));
			end else begin
				x = int'(clamp_coord(x + across));
				y = int'(clamp_coord(y + along));
			end
			t = t + (($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 60000));
			send_sample(EV_MOVE, clamp_coord(x), clamp_coord(y), t, 1'b0, G_NONE);
		end
		t = t + $urandom_range(0, 1000);
		send_sample(EV_UP, clamp_coord(x), clamp_coord(y), t, 1'b0, G_NONE);
	endtask

	// Drives one or both distance sums into saturation. An idle sample resets the previous
	// position without adding, so repeating idle-then-move pairs across the
	// full range keeps adding the same full-scale step.
	task automatic run_pump();
		int axis;
		logic [COORD_W-1:0] from, to, fx, fy, tx, ty;
		logic [TIME_W-1:0] t;
		t = $urandom();
		axis = int'($urandom_range(0, 2));
		from = ($urandom_range(0, 1) == 0) ? '0 : COORD_MAX;
		to = ~from;
		fx = (axis != 1) ? from : COORD_MID;
		fy = (axis != 0) ? from : COORD_MID;
		tx = (axis != 1) ? to : COORD_MID;
		ty = (axis != 0) ? to : COORD_MID;
		send_sample(EV_DOWN, fx, fy, t, 1'b0, G_NONE);
		repeat ($urandom_range(33, 40)) begin
			send_sample(EV_NONE, fx, fy, t, 1'b0, G_NONE);
			t = t + 32'd100000;
			send_sample(EV_MOVE, tx, ty, t, 1'b0, G_NONE);
		end
		// One step back out of saturation before lifting.
		t = t + 32'd100000;
		send_sample(EV_MOVE, fx, fy, t, 1'b0, G_NONE);
		send_sample(EV_UP, fx, fy, t, 1'b0, G_NONE);
	endtask

	// Samples with every field random, including moves and ups that have no
	// down in front of them.
	task automatic run_noise();
		repeat ($urandom_range(1, 6))
			send_sample(event_t'($urandom_range(0, 3)), COORD_W'($urandom()),
				COORD_W'($urandom()), $urandom(), 1'b0, G_NONE);
	endtask

	// Result side: out_ready drops for random stretches.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				hold_cycles = pick_gap();
		end
	end

	// Compares every accepted gesture with the oldest owed one and watches
	// for a hung run.
	always @(posedge clk) begin : check_results
		gesture_t want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (out_valid && out_ready) begin
				if (gesture_q.size() == 0) begin
					errors++;
					$display("%0t: gesture %0d arrived with none expected", $time, gesture);
				end else begin
					want = gesture_q.pop_front();
					if (gesture !== want) begin
						errors++;
						$display("%0t: gesture mismatch, expected %0d (%s), got %0d",
							$time, want, want.name(), gesture);
					end
				end
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: nothing accepted for %0d cycles", $time, STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int phase, phase_end, pick;
		// Reset is held from time zero and released on a falling edge.
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table under the reset thresholds.
		foreach (dir_rows[i])
			send_sample(dir_rows[i].ev, dir_rows[i].x, dir_rows[i].y, dir_rows[i].t,
				dir_rows[i].fixed, dir_rows[i].want);

		// Random part, one threshold setting per phase. The first phase keeps
		// the reset values, the last writes them back explicitly.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: ;
				1: set_thresholds('0, '0, '0);
				2: set_thresholds('1, '1, '1);
				3: set_thresholds(LIMIT_W'(20), LIMIT_W'(10), TIME_W'(1000));
				4: set_thresholds(LIMIT_W'($urandom()), LIMIT_W'($urandom()), $urandom());
				5: set_thresholds(LIMIT_W'($urandom_range(0, 400)),
					LIMIT_W'($urandom_range(0, 200)), $urandom_range(0, 200000));
				default: set_thresholds(TAP_MAX_RESET, SLIDE_DIST_RESET, SLIDE_TIME_RESET);
			endcase
			phase_end = items + ITEMS_PER_PHASE;
			while (items < phase_end) begin
				// Now and then switch between idling and back-to-back traffic.
				if ($urandom_range(0, 14) == 0)
					no_idle = ($urandom_range(0, 2) == 0);
				pick = int'($urandom_range(0, 99));
				if (pick < 70)
					run_swipe();
				else if (pick < 72)
					run_pump();
				else if (pick < 97)
					run_noise();
				else
					drain();
			end
		end

		drain();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ touch_swipe_tap_classifier.f @@
rtl/tstc_pkg.sv
rtl/tstc_cfg.sv
rtl/tstc_track.sv
rtl/tstc_classify.sv
rtl/touch_swipe_tap_classifier.sv
test/testbench.sv
